// ===== hw/rtl/ntis_pkg.sv =====
// Package for the nearest-center inverse-CDF sampler: sizes, item kinds and field widths.
`default_nettype none

package ntis_pkg;

    localparam int MAX_TABLES  = 32;
    localparam int MAX_SUPPORT = 256;

    localparam int TBL_AW = $clog2(MAX_TABLES);
    localparam int ENT_AW = $clog2(MAX_SUPPORT);
    localparam int LVL_AW = TBL_AW + ENT_AW;

    localparam int VAL_W = 24;
    localparam int CNT_W = 9;
    localparam int RND_W = 16;
    localparam int NT_W  = 6;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        KIND_CENTER = 2'd0,
        KIND_LEVEL  = 2'd1,
        KIND_COUNT  = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_table_inverse_cdf_sampler.sv =====
// Nearest-center inverse-CDF sampler: center scan, count lookup, level lookup.
//
// Load items (center, level, support count) are written straight from idle. A
// sample item scans the center memory one entry per cycle until it finds the
// first center at or above the previous value, or reaches the last table in
// use, then reads the count, forms the index multiply, reads the level and
// hands the result off before it returns to idle. A table with a zero count
// skips the multiply and level read, and with no tables a sample goes straight
// to the hand-off, which waits while the output is stalled. The result waits
// in an output register, so a new item is taken while it is still pending.
// Memories are not cleared at reset; reading a center, count or level that was
// never loaded gives undefined fields.
`default_nettype none

module nearest_table_inverse_cdf_sampler
    import ntis_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration: num_tables
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [NT_W-1:0]       i_cfg_data,
    // tdata: table_index, entry_index, support_count, load_value,
    //        previous_value, random_fraction, 2 pad bits
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: sample_value, chosen_table, chosen_entry, 3 pad bits
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: empty_flag
    output logic                       m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CREAD, S_MUL, S_POS, S_LVL, S_DONE
    } t_state;

    // input fields
    logic [TBL_AW-1:0]        w_tix;
    logic [ENT_AW-1:0]        w_eix;
    logic [CNT_W-1:0]         w_cnt;
    logic signed [VAL_W-1:0]  w_lval;
    logic signed [VAL_W-1:0]  w_prev;
    logic [RND_W-1:0]         w_rnd;
    t_kind                    w_kind;

    assign w_tix  = s_axis_tdata[4:0];
    assign w_eix  = s_axis_tdata[12:5];
    assign w_cnt  = s_axis_tdata[21:13];
    assign w_lval = s_axis_tdata[45:22];
    assign w_prev = s_axis_tdata[69:46];
    assign w_rnd  = s_axis_tdata[85:70];
    assign w_kind = t_kind'(s_axis_tuser);

    // memories
    logic signed [VAL_W-1:0] r_center_mem [MAX_TABLES];
    logic [CNT_W-1:0]        r_count_mem  [MAX_TABLES];
    logic signed [VAL_W-1:0] r_level_mem  [MAX_TABLES*MAX_SUPPORT];

    logic signed [VAL_W-1:0] r_c_rd;
    logic [CNT_W-1:0]        r_cnt_rd;
    logic signed [VAL_W-1:0] r_l_rd;

    // control and datapath registers
    t_state                  r_state, n_state;
    logic [NT_W-1:0]         r_num_tables, n_num_tables;
    logic [TBL_AW-1:0]       r_idx, n_idx;
    logic [TBL_AW-1:0]       r_sel, n_sel;
    logic signed [VAL_W-1:0] r_prev, n_prev;
    logic [RND_W-1:0]        r_rnd, n_rnd;
    logic signed [VAL_W-1:0] r_prev_c, n_prev_c;
    logic [24:0]             r_prod, n_prod;
    logic signed [VAL_W-1:0] r_res_val, n_res_val;
    logic [TBL_AW-1:0]       r_res_tbl, n_res_tbl;
    logic [ENT_AW-1:0]       r_res_ent, n_res_ent;
    logic                    r_res_empty, n_res_empty;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic                    r_out_empty, n_out_empty;

    logic                    w_in_xfer;
    logic                    w_cfg_xfer;
    logic                    w_out_free;
    logic [NT_W-1:0]         w_n;
    logic [TBL_AW-1:0]       w_c_addr;
    logic                    w_c_wr, w_cnt_wr, w_l_wr;
    logic [CNT_W-1:0]        w_cnt_clamped;
    logic signed [24:0]      w_d_cur, w_d_low;
    logic [24:0]             w_a_cur, w_a_low;
    logic [CNT_W-1:0]        w_cm1;
    logic [CNT_W-1:0]        w_pos_raw;
    logic [ENT_AW-1:0]       w_pos;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_n = (r_num_tables > NT_W'(MAX_TABLES)) ? NT_W'(MAX_TABLES) : r_num_tables;

    // load decode
    always_comb begin
        w_c_wr   = 1'b0;
        w_l_wr   = 1'b0;
        w_cnt_wr = 1'b0;
        if (w_in_xfer) begin
            unique case (w_kind)
                KIND_CENTER: w_c_wr   = 1'b1;
                KIND_LEVEL:  w_l_wr   = 1'b1;
                KIND_COUNT:  w_cnt_wr = 1'b1;
                KIND_SAMPLE: ;
                default: ;
            endcase
        end
    end

    assign w_cnt_clamped = (w_cnt > CNT_W'(MAX_SUPPORT)) ? CNT_W'(MAX_SUPPORT) : w_cnt;

    // data for r_idx arrives while r_idx+1 is being read
    assign w_c_addr = (r_state == S_SCAN) ? r_idx + TBL_AW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (w_c_wr) begin
            r_center_mem[w_tix] <= w_lval;
        end
        r_c_rd <= r_center_mem[w_c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_wr) begin
            r_count_mem[w_tix] <= w_cnt_clamped;
        end
        r_cnt_rd <= r_count_mem[r_sel];
    end

    always_ff @(posedge i_clk) begin
        if (w_l_wr) begin
            r_level_mem[{w_tix, w_eix}] <= w_lval;
        end
        r_l_rd <= r_level_mem[{r_sel, w_pos}];
    end

    // distances for the nearest-center tie rule
    assign w_d_cur = 25'(r_c_rd) - 25'(r_prev);
    assign w_d_low = 25'(r_prev_c) - 25'(r_prev);
    assign w_a_cur = w_d_cur[24] ? 25'(-w_d_cur) : 25'(w_d_cur);
    assign w_a_low = w_d_low[24] ? 25'(-w_d_low) : 25'(w_d_low);

    // entry position = round(rnd * (count-1) / 65536), clamped to count-1
    assign w_cm1     = r_cnt_rd - CNT_W'(1);
    assign w_pos_raw = r_prod[24:16];
    assign w_pos     = (w_pos_raw > w_cm1) ? w_cm1[ENT_AW-1:0] : w_pos_raw[ENT_AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_num_tables = r_num_tables;
        n_idx        = r_idx;
        n_sel        = r_sel;
        n_prev       = r_prev;
        n_rnd        = r_rnd;
        n_prev_c     = r_prev_c;
        n_prod       = r_prod;
        n_res_val    = r_res_val;
        n_res_tbl    = r_res_tbl;
        n_res_ent    = r_res_ent;
        n_res_empty  = r_res_empty;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_empty  = r_out_empty;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_cfg_xfer) begin
            n_num_tables = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && w_kind == KIND_SAMPLE) begin
                    n_prev = w_prev;
                    n_rnd  = w_rnd;
                    n_idx  = '0;
                    if (w_n == '0) begin
                        n_res_val   = '0;
                        n_res_tbl   = '0;
                        n_res_ent   = '0;
                        n_res_empty = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_c_rd >= r_prev) begin
                    if (r_idx != '0 && w_a_low < w_a_cur) begin
                        n_sel = r_idx - TBL_AW'(1);
                    end else begin
                        n_sel = r_idx;
                    end
                    n_state = S_CREAD;
                end else if ({1'b0, r_idx} == w_n - NT_W'(1)) begin
                    // above every center: last table in use
                    n_sel   = r_idx;
                    n_state = S_CREAD;
                end else begin
                    n_prev_c = r_c_rd;
                    n_idx    = r_idx + TBL_AW'(1);
                end
            end
            S_CREAD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt_rd == '0) begin
                    n_res_val   = '0;
                    n_res_tbl   = r_sel;
                    n_res_ent   = '0;
                    n_res_empty = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_prod  = 25'(r_rnd) * 25'(w_cm1) + 25'h8000;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = S_LVL;
            end
            S_LVL: begin
                n_res_val   = r_l_rd;
                n_res_tbl   = r_sel;
                n_res_ent   = w_pos;
                n_res_empty = 1'b0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_res_ent, r_res_tbl, r_res_val};
                    n_out_empty = r_res_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_tables <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_num_tables <= n_num_tables;
            r_out_valid  <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_sel       <= n_sel;
        r_prev      <= n_prev;
        r_rnd       <= n_rnd;
        r_prev_c    <= n_prev_c;
        r_prod      <= n_prod;
        r_res_val   <= n_res_val;
        r_res_tbl   <= n_res_tbl;
        r_res_ent   <= n_res_ent;
        r_res_empty <= n_res_empty;
        r_out_data  <= n_out_data;
        r_out_empty <= n_out_empty;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_empty;

endmodule

`default_nettype wire

// ===== dv/ntis_draw_checker.sv =====
`timescale 1ns / 1ps
// Checker for the inverse-CDF sampler: mirrors the loaded tables and scores every draw.

module ntis_draw_checker
    import ntis_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [NT_W-1:0]       i_cfg_data,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // tdata: table_index, entry_index, support_count, load_value,
    //        previous_value, random_fraction, 2 pad bits
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: kind
    input  wire logic [1:0]            i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: sample_value, chosen_table, chosen_entry, 3 pad bits
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    // tuser: empty_flag
    input  wire logic                  i_m_tuser,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [TBL_AW-1:0] tbl;
        logic [ENT_AW-1:0] entry;
        logic              empty;
    } t_draw;

    logic signed [VAL_W-1:0] ctr_mem [MAX_TABLES];
    int                      cnt_mem [MAX_TABLES];
    logic [VAL_W-1:0]        lvl_mem [MAX_TABLES][MAX_SUPPORT];
    int                      tables_cfg;
    t_draw                   draw_q [$];
    int                      fail_total;
    int                      outstanding;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;

    initial begin
        tables_cfg  = 0;
        fail_total  = 0;
        outstanding = 0;
        foreach (ctr_mem[t]) begin
            ctr_mem[t] = '0;
            cnt_mem[t] = 0;
        end
        foreach (lvl_mem[t, e]) lvl_mem[t][e] = '0;
    end

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_draw predict_draw(input int prev, input int frac);
        t_draw d;
        int    n;
        int    idx;
        int    cnt;
        int    pos;
        d = '0;
        n = (tables_cfg > MAX_TABLES) ? MAX_TABLES : tables_cfg;
        if (n == 0) begin
            d.empty = 1'b1;
            return d;
        end
        // first center at or above prev, then the lower neighbor only if strictly closer
        idx = 0;
        while (idx < n && int'(ctr_mem[idx]) < prev) idx++;
        if (idx >= n) begin
            idx = n - 1;
        end else if (idx > 0) begin
            if (span(int'(ctr_mem[idx-1]), prev) < span(int'(ctr_mem[idx]), prev))
                idx--;
        end
        d.tbl = idx[TBL_AW-1:0];
        cnt = cnt_mem[idx];
        if (cnt == 0) begin
            d.empty = 1'b1;
            return d;
        end
        pos = (frac * (cnt - 1) + 32768) >> 16;
        if (pos > cnt - 1) pos = cnt - 1;
        d.value = lvl_mem[idx][pos];
        d.entry = pos[ENT_AW-1:0];
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] draw mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_draw got;
        t_draw want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) tables_cfg = int'(i_cfg_data);
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    KIND_CENTER: ctr_mem[i_s_tdata[4:0]] = i_s_tdata[45:22];
                    KIND_LEVEL:  lvl_mem[i_s_tdata[4:0]][i_s_tdata[12:5]] = i_s_tdata[45:22];
                    KIND_COUNT: begin
                        cnt_mem[i_s_tdata[4:0]] = (int'(i_s_tdata[21:13]) > MAX_SUPPORT) ?
                                                  MAX_SUPPORT : int'(i_s_tdata[21:13]);
                    end
                    default: begin
                        draw_q.insert(draw_q.size(),
                                      predict_draw($signed(i_s_tdata[69:46]),
                                                   int'(i_s_tdata[85:70])));
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[23:0];
                got.tbl   = i_m_tdata[28:24];
                got.entry = i_m_tdata[36:29];
                got.empty = i_m_tuser;
                if (draw_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(i_m_tdata[36:0]), 0);
                end else begin
                    want = draw_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("sample_value", int'(got.value), int'(want.value));
                    if (got.tbl !== want.tbl)
                        report_mismatch("chosen_table", int'(got.tbl), int'(want.tbl));
                    if (got.entry !== want.entry)
                        report_mismatch("chosen_entry", int'(got.entry), int'(want.entry));
                    if (got.empty !== want.empty)
                        report_mismatch("empty_flag", int'(got.empty), int'(want.empty));
                end
            end
            outstanding = draw_q.size();
        end
    end

endmodule

// ===== dv/nearest_table_inverse_cdf_sampler_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the inverse-CDF sampler: clock, reset, stimulus, flow control and verdict.

module nearest_table_inverse_cdf_sampler_tb;
    import ntis_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [NT_W-1:0]       cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int fail_count;
    int pending;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_requests = 0;
    int items_sent    = 0;
    int tables_in_use = 0;
    int ctr_seen [MAX_TABLES];
    bit lvl_ok   [MAX_TABLES][MAX_SUPPORT];

    nearest_table_inverse_cdf_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    ntis_draw_checker draw_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    function automatic logic [VAL_W-1:0] pick24();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge; tvalid stays high into the next item
    task automatic send_item(input t_kind kind, input logic [TBL_AW-1:0] tix,
                             input logic [ENT_AW-1:0] eix, input logic [CNT_W-1:0] cnt,
                             input logic [VAL_W-1:0] lval, input logic [VAL_W-1:0] prev,
                             input logic [RND_W-1:0] frac);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, frac, prev, lval, cnt, eix, tix};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_center(input int t, input logic [VAL_W-1:0] v);
        ctr_seen[t] = int'($signed(v));
        send_item(KIND_CENTER, TBL_AW'(t), ENT_AW'($urandom), CNT_W'($urandom), v,
                  VAL_W'($urandom), RND_W'($urandom));
    endtask

    task automatic load_level(input int t, input int e, input logic [VAL_W-1:0] v);
        lvl_ok[t][e] = 1'b1;
        send_item(KIND_LEVEL, TBL_AW'(t), ENT_AW'(e), CNT_W'($urandom), v,
                  VAL_W'($urandom), RND_W'($urandom));
    endtask

    // levels below the new count are filled first so no draw reads an empty slot
    task automatic load_count(input int t, input int c);
        int fill;
        fill = (c > MAX_SUPPORT) ? MAX_SUPPORT : c;
        for (int e = 0; e < fill; e++)
            if (!lvl_ok[t][e]) load_level(t, e, pick24());
        send_item(KIND_COUNT, TBL_AW'(t), ENT_AW'($urandom), CNT_W'(c), VAL_W'($urandom),
                  VAL_W'($urandom), RND_W'($urandom));
    endtask

    task automatic draw(input int prev, input int frac);
        send_item(KIND_SAMPLE, TBL_AW'($urandom), ENT_AW'($urandom), CNT_W'($urandom),
                  VAL_W'($urandom), VAL_W'(prev), RND_W'(frac));
    endtask

    task automatic settle_and_config(input int n);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_data  <= NT_W'(n);
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        tables_in_use = (n > MAX_TABLES) ? MAX_TABLES : n;
    endtask

    task automatic resort_centers();
        int base;
        base = -8388608 + $urandom_range(0, 24'h100000);
        for (int t = 0; t < MAX_TABLES; t++) begin
            load_center(t, base[VAL_W-1:0]);
            // a zero step now and then gives duplicate centers
            base += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24'h3F000);
        end
    endtask

    task automatic random_draw();
        int t;
        int prev;
        int frac;
        t = (tables_in_use == 0) ? 0 : $urandom_range(0, tables_in_use - 1);
        case ($urandom_range(0, 5))
            0: prev = ctr_seen[t];
            1: prev = ctr_seen[t] + $urandom_range(0, 6) - 3;
            2, 3: begin
                if (t > 0)
                    prev = ((ctr_seen[t-1] + ctr_seen[t]) >>> 1) + $urandom_range(0, 2) - 1;
                else
                    prev = ctr_seen[t];
            end
            4: prev = $signed(pick24());
            default: prev = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: frac = 0;
            1: frac = 16'hFFFF;
            2: frac = 16'h8000 + $urandom_range(0, 4) - 2;
            default: frac = $urandom;
        endcase
        draw(prev, frac);
    endtask

    task automatic random_count();
        int r;
        int c;
        int tix;
        tix = $urandom_range(0, MAX_TABLES - 1);
        r = $urandom_range(0, 99);
        if (r < 20)      c = 0;
        else if (r < 60) c = $urandom_range(1, 4);
        else if (r < 90) c = $urandom_range(5, 16);
        else if (r < 95) c = MAX_SUPPORT;
        else             c = $urandom_range(MAX_SUPPORT + 1, 511);
        // full-size counts go to tables whose levels are all loaded already
        if (c >= MAX_SUPPORT) tix = ($urandom_range(0, 1) != 0) ? 5 : 7;
        load_count(tix, c);
    endtask

    initial begin
        int phase_tables [12];
        int phase_end;
        int pick;
        int n;
        int t;
        phase_tables = '{32, 1, 63, 0, 17, 40, 2, 32, 0, 31, 5, 32};
        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        foreach (ctr_seen[k]) ctr_seen[k] = 0;
        foreach (lvl_ok[k, e]) lvl_ok[k][e] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no tables: both ends of the value range
        settle_and_config(0);
        draw(-8388608, 0);
        draw(8388607, 16'hFFFF);

        // evenly spaced inner centers, with both extremes at the ends
        for (int k = 0; k < MAX_TABLES; k++) begin
            if (k == 0)                   load_center(k, 24'h800000);
            else if (k == MAX_TABLES - 1) load_center(k, 24'h7FFFFF);
            else                          load_center(k, VAL_W'((k - 16) * 262144));
        end
        for (int k = 0; k < MAX_TABLES; k++) begin
            case (k)
                3:  load_count(k, 0);
                5:  load_count(k, MAX_SUPPORT);
                7:  load_count(k, 511);
                9:  load_count(k, 1);
                31: load_count(k, 2);
                default: load_count(k, $urandom_range(1, 6));
            endcase
        end

        settle_and_config(MAX_TABLES);
        draw(-8388608, $urandom);
        draw(8388607, $urandom);
        draw(ctr_seen[10], 0);
        draw(ctr_seen[10] - 131072, 16'hFFFF);   // exact tie goes to the upper center
        draw(ctr_seen[10] - 131073, 16'h8000);   // lower center strictly closer
        draw(ctr_seen[3], $urandom);             // zero support
        draw(ctr_seen[5], 16'hFFFF);
        draw(ctr_seen[5], 0);
        draw(ctr_seen[5], 16'h8000);
        draw(ctr_seen[7], 16'hFFFF);             // count stored clipped
        draw(ctr_seen[9], 16'hFFFF);
        draw(ctr_seen[31] - 1, 16'h7FFF);
        draw(ctr_seen[31] - 1, 16'h8000);

        settle_and_config(1);
        draw(8388607, 16'hFFFF);                 // above every center in use
        draw(-8388608, 0);
        settle_and_config(40);
        draw(8388607, 16'hFFFF);
        settle_and_config(63);
        draw(ctr_seen[20] + 5, $urandom);

        for (int ph = 0; ph < 12; ph++) begin
            n = (ph == 8) ? $urandom_range(0, 63) : phase_tables[ph];
            settle_and_config(n);
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 88; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 88; end
                default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
            endcase
            // long result hold-off while the input side keeps pushing
            if (ph == 0 || ph == 4) hold_requests++;
            if (ph % 2 == 0) resort_centers();
            phase_end = items_sent + 75;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                t    = $urandom_range(0, MAX_TABLES - 1);
                if (pick < 70) begin
                    random_draw();
                end else if (pick < 80) begin
                    load_level(t, $urandom_range(0, MAX_SUPPORT - 1), pick24());
                end else if (pick < 90) begin
                    if ($urandom_range(0, 1))
                        load_center(t, VAL_W'(ctr_seen[t] + $urandom_range(0, 4096) - 2048));
                    else
                        load_center(t, pick24());
                end else begin
                    random_count();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ntis_pkg.sv
hw/rtl/nearest_table_inverse_cdf_sampler.sv
dv/ntis_draw_checker.sv
dv/nearest_table_inverse_cdf_sampler_tb.sv
